>>> rtl/core/round_robin_anticipatory_io_scheduler_unit_assert.svh
// Assertion macros for the anticipatory scheduler.
// Depends on nothing; included by the top level.
`ifndef ROUND_ROBIN_ANTICIPATORY_IO_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_ANTICIPATORY_IO_SCHEDULER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RRAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RRAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/rras_pkg.sv
// Package of the anticipatory scheduler: widths, codes and a helper function.
// Depends on nothing.
package rras_pkg;
  localparam int DefNumClients = 32;
  localparam int DefReqsPerClient = 8;
  localparam int KbShift = 10;
  localparam int ReqW = 81;

  typedef enum logic [1:0] {
    K_ARRIVE = 2'd0, K_COMPLETE = 2'd1, K_TICK = 2'd2, K_PULL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0, ST_WAITREQ = 2'd1, ST_WAITING = 2'd2, ST_BAD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_IN_FLIGHT = 2'd0, CFG_WAIT_TICKS = 2'd1,
    CFG_SLICE_TICKS = 2'd2, CFG_BUDGET_KB = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0, PH_READ = 2'd1, PH_EXEC = 2'd2, PH_OUT = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [47:0] offset;
    logic [23:0] length;
    logic        rd;
  } req_t;

  function automatic logic [15:0] min2(input logic [15:0] v);
    return (v < 16'd2) ? 16'd2 : v;
  endfunction
endpackage

>>> rtl/core/rras_req_mem.sv
// Request store: one synchronous memory of queued requests with a registered read.
// Depends on rras_pkg.
module rras_req_mem #(
  parameter int Depth = 256,
  parameter int AW = 8
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  rras_pkg::req_t wdata,
  input  logic [AW-1:0]  raddr,
  output rras_pkg::req_t rdata
);
  import rras_pkg::*;
  req_t mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/rras_client_mem.sv
// Per-client table: status, service, slice end, FIFO head and count.
// Synchronous memory with registered read; reset state through valid bits.
// Depends on rras_pkg.
module rras_client_mem #(
  parameter int NumClients = 32,
  parameter int CW = 5,
  parameter int QW = 3,
  parameter int NW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [CW-1:0] waddr,
  input  logic [1:0]    w_status,
  input  logic [26:0]   w_service,
  input  logic [31:0]   w_slice_end,
  input  logic [QW-1:0] w_head,
  input  logic [NW-1:0] w_count,
  input  logic [CW-1:0] raddr,
  output logic [1:0]    r_status,
  output logic [26:0]   r_service,
  output logic [31:0]   r_slice_end,
  output logic [QW-1:0] r_head,
  output logic [NW-1:0] r_count
);
  import rras_pkg::*;
  localparam int EW = 2 + 27 + 32 + QW + NW;
  logic [EW-1:0] mem [NumClients];
  logic [NumClients-1:0] vld;
  logic [EW-1:0] rd;
  logic rv;
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {w_status, w_service, w_slice_end, w_head, w_count};
    end
    rd <= mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rv <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rv <= vld[raddr];
    end
  end
  // Entries never written read as the reset value; slice end is don't-care.
  assign r_status    = rv ? rd[EW-1 -: 2] : 2'd0;
  assign r_service   = rv ? rd[EW-3 -: 27] : 27'd0;
  assign r_slice_end = rd[QW+NW+31 -: 32];
  assign r_head      = rv ? rd[QW+NW-1 -: QW] : '0;
  assign r_count     = rv ? rd[NW-1:0] : '0;
endmodule

>>> rtl/core/round_robin_anticipatory_io_scheduler_unit.sv
// Round-robin anticipatory disk request scheduler, top level.
// Channels: an event input (kind, client, request fields) with valid/stall,
// and a result output (accepted, dispatched and the dispatched request)
// with out_valid/out_stall. Every input beat gives exactly one result beat.
// An accepted event passes through a read cycle that addresses the client
// table and request store, an execute cycle that works on the registered
// read data and writes back, and an output cycle in which the result
// register is offered. The block returns to idle after the result beat and
// takes the next event only there, so it does not take a new event before
// the last one is delivered; the registered reads of the client memory and
// request memory set the split into read and execute cycles.
// When the receiver stalls, the result stays in its register and no new
// event is taken until it is delivered.
// Reset (rst, synchronous) restores the default registers, empties every
// queue and the ring, and clears the per-client table through valid bits,
// so the block accepts events in the first cycle after reset.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// Depends on rras_pkg, rras_client_mem, rras_req_mem and the assert header.
module round_robin_anticipatory_io_scheduler_unit #(
  parameter int NUM_CLIENTS = rras_pkg::DefNumClients,
  parameter int REQS_PER_CLIENT = rras_pkg::DefReqsPerClient
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [4:0]  client,
  input  logic [7:0]  req_tag,
  input  logic [47:0] req_offset,
  input  logic [23:0] req_length,
  input  logic        is_read,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        dispatched,
  output logic [4:0]  out_client,
  output logic [7:0]  out_tag,
  output logic [47:0] out_offset,
  output logic [23:0] out_length,
  output logic        out_is_read
);
  import rras_pkg::*;

  localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int QW = (REQS_PER_CLIENT > 1) ? $clog2(REQS_PER_CLIENT) : 1;
  localparam int NW = $clog2(REQS_PER_CLIENT + 1);
  localparam int RW = $clog2(NUM_CLIENTS + 1);
  localparam int DEPTH = NUM_CLIENTS * REQS_PER_CLIENT;
  localparam int AW = CW + QW;

  // Configuration registers.
  logic [5:0]  max_in_flight;
  logic [15:0] wait_ticks, slice_ticks;
  logic [16:0] budget_kb;

  // Scalar state.
  logic [31:0] now_ticks;
  logic [5:0]  in_flight;
  logic        active_valid;
  logic [CW-1:0] active_client;
  logic [15:0] wait_timer;
  logic [CW-1:0] ring [NUM_CLIENTS];
  logic [CW-1:0] ring_head;
  logic [RW-1:0] ring_count;

  // Sequencer and captured event.
  phase_t phase, phase_next;
  logic [1:0]  ev_kind;
  logic [4:0]  ev_client;
  req_t        ev_req;
  logic [CW-1:0] sel;        // client addressed in the table
  logic        sel_ok;       // client slot in range / pull allowed to proceed
  logic        pull_new;     // pull takes a new client from the ring

  // Result register.
  logic        res_acc, res_disp;
  logic [4:0]  res_client;
  req_t        res_req;

  // Memory ports.
  logic          cm_we;
  logic [CW-1:0] cm_raddr;
  logic [1:0]    r_status, w_status;
  logic [26:0]   r_service, w_service;
  logic [31:0]   r_slice_end, w_slice_end;
  logic [QW-1:0] r_head, w_head;
  logic [NW-1:0] r_count, w_count;
  logic          rm_we;
  logic [AW-1:0] rm_waddr, rm_raddr;
  req_t          rm_rdata;

  rras_client_mem #(.NumClients(NUM_CLIENTS), .CW(CW), .QW(QW), .NW(NW)) u_cmem (
    .clk, .rst, .we(cm_we), .waddr(sel),
    .w_status, .w_service, .w_slice_end, .w_head, .w_count,
    .raddr(cm_raddr), .r_status, .r_service, .r_slice_end, .r_head, .r_count
  );

  rras_req_mem #(.Depth(DEPTH), .AW(AW)) u_rmem (
    .clk, .we(rm_we), .waddr(rm_waddr), .wdata(ev_req),
    .raddr(rm_raddr), .rdata(rm_rdata)
  );

  assign in_stall  = (phase != PH_IDLE);
  assign out_valid = (phase == PH_OUT);
  assign accepted    = res_acc;
  assign dispatched  = res_disp;
  assign out_client  = res_client;
  assign out_tag     = res_req.tag;
  assign out_offset  = res_req.offset;
  assign out_length  = res_req.length;
  assign out_is_read = res_req.rd;

  always_comb begin
    unique case (phase)
      PH_IDLE: phase_next = (in_valid) ? PH_READ : PH_IDLE;
      PH_READ: phase_next = PH_EXEC;
      PH_EXEC: phase_next = PH_OUT;
      PH_OUT:  phase_next = out_stall ? PH_OUT : PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  // Effective configuration values.
  logic [5:0]  eff_depth;
  logic [26:0] eff_budget;
  always_comb begin
    eff_depth = (max_in_flight == 6'd0) ? 6'd1 :
                (max_in_flight > 6'd50) ? 6'd50 : max_in_flight;
    if (budget_kb < 17'd16) begin
      eff_budget = 27'(17'd16) << KbShift;
    end else if (budget_kb > 17'd65536) begin
      eff_budget = 27'(17'd65536) << KbShift;
    end else begin
      eff_budget = 27'(budget_kb) << KbShift;
    end
  end

  // In the read cycle the table address is the event client, the active client on
  // a tick or on a pull while a client is active, or else the ring head on a pull.
  logic [CW-1:0] pull_c;
  always_comb begin
    pull_c = active_valid ? active_client : ring[ring_head];
    cm_raddr = (ev_kind == K_PULL) ? pull_c : ev_client[CW-1:0];
    if (ev_kind == K_TICK) begin
      cm_raddr = active_client;
    end
  end

  // Execute cycle: combine table data, decide writes.
  logic [NW-1:0] q_count_new;
  logic [26:0]   svc_sum;
  logic          has_next, expired, ex_disp;
  logic          arrive_ok, pull_go;
  logic [31:0]   slice_end_use, slice_diff;
  logic [QW-1:0] tail;
  always_comb begin
    cm_we = 1'b0;
    rm_we = 1'b0;
    w_status = r_status;
    w_service = r_service;
    w_slice_end = r_slice_end;
    w_head = r_head;
    w_count = r_count;
    tail = QW'((32'(r_head) + 32'(r_count)) % REQS_PER_CLIENT);
    rm_waddr = AW'((32'(sel) * REQS_PER_CLIENT) + 32'(tail));
    slice_end_use = (r_service == 27'd0) ? now_ticks + 32'(min2(slice_ticks)) : r_slice_end;
    slice_diff = now_ticks - slice_end_use;
    svc_sum = r_service + 27'(rm_rdata.length);
    q_count_new = r_count - NW'(1);
    has_next = (q_count_new != '0);
    expired = (svc_sum >= eff_budget) || !slice_diff[31];
    // A pull from the active client proceeds only while that client is ready.
    pull_go = sel_ok && (pull_new || r_status == ST_READY);
    ex_disp = 1'b0;
    arrive_ok = 1'b0;
    if (phase == PH_EXEC && sel_ok) begin
      unique case (kind_t'(ev_kind))
        K_ARRIVE: begin
          if (32'(r_count) < REQS_PER_CLIENT) begin
            arrive_ok = 1'b1;
            cm_we = 1'b1;
            rm_we = 1'b1;
            w_status = ST_READY;
            if (r_count == '0 && !(active_valid && active_client == sel)) begin
              w_service = 27'd0;
            end
            w_count = r_count + NW'(1);
          end
        end
        K_COMPLETE: begin
          if (active_valid && active_client == sel && r_status == ST_WAITREQ) begin
            cm_we = 1'b1;
            w_status = ST_WAITING;
          end
        end
        K_TICK: ;
        K_PULL: begin
          if (pull_go && r_count != '0) begin
            ex_disp = 1'b1;
            cm_we = 1'b1;
            w_slice_end = slice_end_use;
            w_head = QW'((32'(r_head) + 1) % REQS_PER_CLIENT);
            w_count = q_count_new;
            w_service = svc_sum;
            if (!expired && !has_next && rm_rdata.rd) begin
              w_status = ST_WAITREQ;
            end else if (has_next && expired) begin
              w_status = ST_READY;
              w_service = 27'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The request store read address needs the head, which arrives with the
  // table data; so the store is addressed from a flip-flop copy of the heads.
  logic [QW-1:0] head_q;
  logic          rdata_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      max_in_flight <= 6'd8;
      wait_ticks <= 16'd5;
      slice_ticks <= 16'd50;
      budget_kb <= 17'd8192;
      now_ticks <= '0;
      in_flight <= '0;
      active_valid <= 1'b0;
      active_client <= '0;
      wait_timer <= '0;
      ring_head <= '0;
      ring_count <= '0;
      res_acc <= 1'b0;
      res_disp <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MAX_IN_FLIGHT: max_in_flight <= cfg_data[5:0];
          CFG_WAIT_TICKS:    wait_ticks <= cfg_data[15:0];
          CFG_SLICE_TICKS:   slice_ticks <= cfg_data[15:0];
          CFG_BUDGET_KB:     budget_kb <= cfg_data;
          default: ;
        endcase
      end
      if (phase == PH_EXEC) begin
        res_acc <= arrive_ok;
        res_disp <= ex_disp;
        unique case (kind_t'(ev_kind))
          K_ARRIVE: begin
            if (arrive_ok && r_count == '0) begin
              if (active_valid && active_client == sel) begin
                wait_timer <= '0;
              end else if (32'(ring_count) < NUM_CLIENTS) begin
                ring[CW'((32'(ring_head) + 32'(ring_count)) % NUM_CLIENTS)] <= sel;
                ring_count <= ring_count + RW'(1);
              end
            end
          end
          K_COMPLETE: begin
            if (in_flight != '0) begin
              in_flight <= in_flight - 6'd1;
            end
            if (sel_ok && active_valid && active_client == sel &&
                r_status == ST_WAITREQ) begin
              wait_timer <= min2(wait_ticks);
            end
          end
          K_TICK: begin
            now_ticks <= now_ticks + 32'd1;
            if (active_valid && r_status == ST_WAITING) begin
              if (wait_timer <= 16'd1) begin
                wait_timer <= '0;
                active_valid <= 1'b0;
              end else begin
                wait_timer <= wait_timer - 16'd1;
              end
            end
          end
          K_PULL: begin
            if (pull_go) begin
              if (pull_new) begin
                ring_head <= CW'((32'(ring_head) + 1) % NUM_CLIENTS);
                active_client <= sel;
              end
              // An expired client with more requests goes to the back of the
              // ring; a client just taken from the ring frees its own place.
              if (ex_disp && has_next && expired &&
                  (pull_new || 32'(ring_count) < NUM_CLIENTS)) begin
                ring[CW'((32'(ring_head) + 32'(ring_count)) % NUM_CLIENTS)] <= sel;
                if (!pull_new) begin
                  ring_count <= ring_count + RW'(1);
                end
              end else if (pull_new) begin
                ring_count <= ring_count - RW'(1);
              end
              // The client stays active while its turn lasts and it either has
              // more requests or anticipates after a read.
              active_valid <= ex_disp && !expired && (has_next || rm_rdata.rd);
              if (ex_disp) begin
                in_flight <= in_flight + 6'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // The pull path needs both the table and the request store, which are
  // read together: PH_READ reads the table; the store reads in the same
  // cycle through a shadow of queue heads kept in flip-flops.
  logic [QW-1:0] head_shadow [NUM_CLIENTS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        head_shadow[i] <= '0;
      end
    end else if (cm_we) begin
      head_shadow[sel] <= w_head;
    end
  end
  assign head_q = head_shadow[cm_raddr];
  assign rdata_ok = 1'b1;

  // Capture stage: event fields, address selection, event eligibility and result fields.
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && in_valid) begin
      ev_kind <= kind;
      ev_client <= client;
      ev_req <= '{tag: req_tag, offset: req_offset, length: req_length, rd: is_read};
    end
    if (phase == PH_READ) begin
      sel <= cm_raddr;
      pull_new <= !active_valid;
      unique case (kind_t'(ev_kind))
        K_ARRIVE, K_COMPLETE: sel_ok <= (32'(ev_client) < NUM_CLIENTS) && rdata_ok;
        K_TICK:  sel_ok <= 1'b1;
        K_PULL:  sel_ok <= (in_flight < eff_depth) &&
                           (active_valid || ring_count != '0);
        default: sel_ok <= 1'b0;
      endcase
    end
    if (phase == PH_EXEC) begin
      res_client <= ex_disp ? 5'(sel) : 5'd0;
      res_req <= ex_disp ? rm_rdata : '0;
    end
  end

  // Store read address: the entry at the queue head of the client that the
  // table is being read for.
  assign rm_raddr = AW'((32'(cm_raddr) * REQS_PER_CLIENT) + 32'(head_q));

`include "round_robin_anticipatory_io_scheduler_unit_assert.svh"

  `RRAS_ASSERT_IMP(a_one_store_write, rm_we, cm_we, "request stored without table update")
  `RRAS_ASSERT_NXT(a_exec_to_out, phase == PH_EXEC, out_valid, "result not presented")
  `RRAS_ASSERT_IMP(a_stall_while_busy, out_valid, in_stall, "input taken while result pending")
  `RRAS_ASSERT_IMP(a_inflight_cap, dispatched && out_valid, in_flight <= 6'd50, "in-flight over limit")
endmodule

>>> tb/tb_round_robin_anticipatory_io_scheduler_unit.sv
// Self-checking testbench for the round-robin anticipatory I/O scheduler.
// Depends on rras_pkg and the scheduler top level.
module tb_round_robin_anticipatory_io_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rras_pkg::*;

  localparam int NCLI = 32;
  localparam int QDEPTH = 8;
  localparam int CYCLE_LIMIT = 400000;

  // One result beat of the scheduler, as the scoreboard keeps it.
  typedef struct packed {
    logic        accepted;
    logic        dispatched;
    logic [4:0]  client;
    logic [7:0]  tag;
    logic [47:0] offset;
    logic [23:0] length;
    logic        rd;
  } sched_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [4:0]  client;
  logic [7:0]  req_tag;
  logic [47:0] req_offset;
  logic [23:0] req_length;
  logic        is_read;
  logic        out_valid;
  logic        out_stall;
  logic        accepted;
  logic        dispatched;
  logic [4:0]  out_client;
  logic [7:0]  out_tag;
  logic [47:0] out_offset;
  logic [23:0] out_length;
  logic        out_is_read;

  round_robin_anticipatory_io_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .client(client), .req_tag(req_tag), .req_offset(req_offset),
    .req_length(req_length), .is_read(is_read),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .dispatched(dispatched), .out_client(out_client),
    .out_tag(out_tag), .out_offset(out_offset), .out_length(out_length),
    .out_is_read(out_is_read)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Scoreboard: results the scheduler still owes, oldest first.
  sched_result_t owed_results[$];
  int mismatch_count = 0;

  // Pacing knobs for the sender and the receiver.
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int hold_cycles = 0;

  // Shadow copy of the scheduler: configuration and all of its state.
  logic [5:0]  shd_max_in_flight;
  logic [15:0] shd_wait_ticks;
  logic [15:0] shd_slice_ticks;
  logic [16:0] shd_budget_kb;

  logic [31:0] now_ticks;
  int          in_flight;
  bit          act_valid;
  int          act_client;
  logic [15:0] wait_timer;
  status_t     cli_status [NCLI];
  logic [26:0] cli_service [NCLI];
  logic [31:0] cli_slice_end [NCLI];
  req_t        req_store [NCLI*QDEPTH];
  int          q_head [NCLI];
  int          q_count [NCLI];
  int          ring [NCLI];
  int          ring_head;
  int          ring_count;

  // Clients whose dispatched requests are still on the disk, used to aim
  // completion events at those clients most of the time.
  int disk_clients[$];

  function automatic void shadow_reset();
    shd_max_in_flight = 6'd8;
    shd_wait_ticks = 16'd5;
    shd_slice_ticks = 16'd50;
    shd_budget_kb = 17'd8192;
    now_ticks = '0;
    in_flight = 0;
    act_valid = 1'b0;
    act_client = 0;
    wait_timer = '0;
    ring_head = 0;
    ring_count = 0;
    for (int i = 0; i < NCLI; i++) begin
      cli_status[i] = ST_READY;
      cli_service[i] = '0;
      q_head[i] = 0;
      q_count[i] = 0;
    end
    disk_clients.delete();
  endfunction

  function automatic int min_two(logic [15:0] v);
    return (v < 16'd2) ? 2 : int'(v);
  endfunction

  function automatic void ring_append(int c);
    if (ring_count >= NCLI) return;
    ring[(ring_head + ring_count) % NCLI] = c;
    ring_count++;
  endfunction

  // Works out the result beat that one event produces and updates the shadow.
  function automatic sched_result_t schedule_event(logic [1:0] k, int c, req_t r);
    sched_result_t res;
    int depth;
    longint budget_bytes;
    bit has_next;
    bit expired;
    req_t head_req;
    res = '{default: '0};
    case (kind_t'(k))
      K_ARRIVE: begin
        if (q_count[c] < QDEPTH) begin
          if (q_count[c] == 0) begin
            if (act_valid && act_client == c) begin
              wait_timer = '0;
            end else begin
              cli_service[c] = '0;
              ring_append(c);
            end
          end
          cli_status[c] = ST_READY;
          req_store[c*QDEPTH + (q_head[c] + q_count[c]) % QDEPTH] = r;
          q_count[c]++;
          res.accepted = 1'b1;
        end
      end
      K_COMPLETE: begin
        if (in_flight > 0) in_flight--;
        if (act_valid && act_client == c && cli_status[c] == ST_WAITREQ) begin
          cli_status[c] = ST_WAITING;
          wait_timer = 16'(min_two(shd_wait_ticks));
        end
      end
      K_TICK: begin
        now_ticks++;
        if (act_valid && cli_status[act_client] == ST_WAITING) begin
          if (wait_timer <= 16'd1) begin
            wait_timer = '0;
            act_valid = 1'b0;
          end else begin
            wait_timer--;
          end
        end
      end
      default: begin
        depth = int'(shd_max_in_flight);
        if (depth < 1) depth = 1;
        if (depth > 50) depth = 50;
        budget_bytes = longint'(shd_budget_kb);
        if (budget_bytes < 16) budget_bytes = 16;
        if (budget_bytes > 65536) budget_bytes = 65536;
        budget_bytes = budget_bytes * 1024;
        if (in_flight >= depth) return res;
        if (act_valid) begin
          if (cli_status[act_client] != ST_READY) return res;
        end else begin
          if (ring_count == 0) return res;
          act_client = ring[ring_head];
          ring_head = (ring_head + 1) % NCLI;
          ring_count--;
          act_valid = 1'b1;
        end
        c = act_client;
        if (q_count[c] == 0) begin
          act_valid = 1'b0;
          return res;
        end
        if (cli_service[c] == '0)
          cli_slice_end[c] = now_ticks + 32'(min_two(shd_slice_ticks));
        head_req = req_store[c*QDEPTH + q_head[c]];
        q_head[c] = (q_head[c] + 1) % QDEPTH;
        q_count[c]--;
        cli_service[c] = cli_service[c] + 27'(head_req.length);
        has_next = q_count[c] != 0;
        expired = (longint'(cli_service[c]) >= budget_bytes) ||
                  ($signed(now_ticks - cli_slice_end[c]) >= 0);
        if (!expired && !has_next && head_req.rd) begin
          cli_status[c] = ST_WAITREQ;
        end else if (has_next && expired) begin
          cli_status[c] = ST_READY;
          cli_service[c] = '0;
          ring_append(c);
          act_valid = 1'b0;
        end else if (!has_next) begin
          act_valid = 1'b0;
        end
        in_flight = (in_flight + 1) & 63;
        disk_clients.push_back(c);
        res.dispatched = 1'b1;
        res.client = 5'(c);
        res.tag = head_req.tag;
        res.offset = head_req.offset;
        res.length = head_req.length;
        res.rd = head_req.rd;
      end
    endcase
    return res;
  endfunction

  // Sends one event beat. The valid is dropped only when a gap is drawn, so
  // back-to-back beats never lower and raise it in the same step.
  task automatic send_event(logic [1:0] k, logic [4:0] c, logic [7:0] tag,
                            logic [47:0] off, logic [23:0] len, logic rd);
    int gap;
    req_t r;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    client <= c;
    req_tag <= tag;
    req_offset <= off;
    req_length <= len;
    is_read <= rd;
    do @(posedge clk); while (in_stall);
    r.tag = tag;
    r.offset = off;
    r.length = len;
    r.rd = rd;
    owed_results.push_back(schedule_event(k, int'(c), r));
  endtask

  // Waits until every owed result beat has come, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [5:0] depth, logic [15:0] wt, logic [15:0] sl,
                              logic [16:0] bud);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_IN_FLIGHT;
    cfg_data <= 17'(depth);
    @(posedge clk);
    cfg_index <= CFG_WAIT_TICKS;
    cfg_data <= 17'(wt);
    @(posedge clk);
    cfg_index <= CFG_SLICE_TICKS;
    cfg_data <= 17'(sl);
    @(posedge clk);
    cfg_index <= CFG_BUDGET_KB;
    cfg_data <= bud;
    @(posedge clk);
    cfg_we <= 1'b0;
    shd_max_in_flight = depth;
    shd_wait_ticks = wt;
    shd_slice_ticks = sl;
    shd_budget_kb = bud;
  endtask

  function automatic logic [47:0] rand_offset();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_arrival(logic [4:0] c, logic [23:0] len, logic rd);
    send_event(K_ARRIVE, c, 8'($urandom), rand_offset(), len, rd);
  endtask

  task automatic send_simple(kind_t k, logic [4:0] c);
    send_event(k, c, 8'($urandom), rand_offset(), 24'($urandom), 1'($urandom));
  endtask

  // Anticipation: a lone read keeps its client active, a pull is refused
  // while it waits, the completion starts the wait and ticks run it out.
  task automatic test_anticipation();
    send_event(K_ARRIVE, 5'd0, 8'h00, 48'h0, 24'h0, 1'b1);
    send_simple(K_PULL, 5'd0);
    send_arrival(5'd1, 24'd4096, 1'b0);
    send_simple(K_PULL, 5'd0);
    send_simple(K_COMPLETE, 5'd0);
    send_simple(K_PULL, 5'd0);
    repeat (6) send_simple(K_TICK, 5'd0);
    send_simple(K_PULL, 5'd0);
    send_simple(K_COMPLETE, 5'd1);
    // A completion with nothing on the disk leaves the count at zero.
    send_simple(K_COMPLETE, 5'd7);
    drain();
  endtask

  // Field extremes, a queue that overflows, and a client that re-enters the ring.
  task automatic test_extremes_and_full_queue();
    send_event(K_ARRIVE, 5'd31, 8'hFF, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 1'b1);
    for (int i = 0; i < 9; i++) send_arrival(5'd5, 24'(i * 512), 1'b1);
    send_simple(K_PULL, 5'd0);
    send_simple(K_PULL, 5'd0);
    send_arrival(5'd31, 24'd100, 1'b1);
    send_simple(K_COMPLETE, 5'd31);
    send_simple(K_PULL, 5'd0);
    drain();
  endtask

  // Random traffic aimed at a few busy clients, with some noise on all slots.
  task automatic run_traffic(int n);
    int pick;
    int c;
    logic [23:0] len;
    for (int i = 0; i < n; i++) begin
      if ((i % 40) == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      if (pick < 35) begin
        len = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535));
        send_arrival(5'(c), len, ($urandom_range(0, 2) != 0));
      end else if (pick < 65) begin
        send_simple(K_PULL, 5'(c));
      end else if (pick < 83) begin
        if (disk_clients.size() != 0 && $urandom_range(0, 4) != 0)
          c = disk_clients.pop_front();
        send_simple(K_COMPLETE, 5'(c));
      end else begin
        send_simple(K_TICK, 5'(c));
      end
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while events keep coming, so
  // the block backs up and stalls its input; then the sender pauses.
  task automatic test_backpressure();
    send_quiet = 1'b1;
    hold_cycles = 300;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_arrival(5'(i % 4), 24'd2048, 1'b0);
      else send_simple(K_PULL, 5'd0);
    end
    drain();
    for (int i = 0; i < 4; i++) send_simple(K_COMPLETE, 5'(i));
    drain();
  endtask

  // Sweeps the registers through their extremes and a middle setting, with traffic in each.
  task automatic test_config_sweep();
    write_config(6'd1, 16'd2, 16'd2, 17'd16);
    run_traffic(100);
    write_config(6'd0, 16'd0, 16'd0, 17'd0);
    run_traffic(80);
    write_config(6'd50, 16'd65535, 16'd65535, 17'd65536);
    run_traffic(100);
    write_config(6'd63, 16'd3, 16'd20, 17'h1FFFF);
    run_traffic(100);
    write_config(6'd4, 16'd4, 16'd30, 17'd64);
    run_traffic(120);
  endtask

  // Receiver: draws a stall per result beat and checks each accepted beat.
  int stall_left = 0;
  initial begin
    sched_result_t got;
    sched_result_t want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{accepted, dispatched, out_client, out_tag, out_offset, out_length,
                out_is_read};
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: %p", got);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
        stall_left = recv_quiet ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (hold_cycles > 0) || (stall_left != 0);
    end
  end

  // The long hold-off counts down on its own.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) hold_cycles--;
    end
  end

  // A hung handshake ends the run here.
  int cycle_count = 0;
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL round_robin_anticipatory_io_scheduler_unit");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_IN_FLIGHT;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = K_ARRIVE;
    client = '0;
    req_tag = '0;
    req_offset = '0;
    req_length = '0;
    is_read = 1'b0;
    shadow_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_anticipation();
    test_extremes_and_full_queue();
    run_traffic(120);
    test_backpressure();
    test_config_sweep();
    drain();
    if (mismatch_count == 0) begin
      $display("PASS round_robin_anticipatory_io_scheduler_unit");
    end else begin
      $display("FAIL round_robin_anticipatory_io_scheduler_unit");
    end
    $finish;
  end
endmodule
